FILE: hw/rtl/widget_hit_test_and_focus_table_assert.svh
// Assertion macros for the widget hit-test and focus table.
// Included by the modules that check their own control logic.
`ifndef WIDGET_HIT_TEST_AND_FOCUS_TABLE_ASSERT_SVH
`define WIDGET_HIT_TEST_AND_FOCUS_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WHFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WHFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/whft_pkg.sv
// Shared types, codes and defaults for the widget hit-test and focus table.
// No dependencies.
`timescale 1ns / 1ps

package whft_pkg;

    localparam int MAX_WIDGETS_DEF = 64;

    localparam logic [2:0] ACT_WRITE   = 3'd0;
    localparam logic [2:0] ACT_HIT     = 3'd1;
    localparam logic [2:0] ACT_NEXT    = 3'd2;
    localparam logic [2:0] ACT_PREV    = 3'd3;
    localparam logic [2:0] ACT_HOLD    = 3'd4;
    localparam logic [2:0] ACT_RELEASE = 3'd5;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_RANGE = 2'd1;
    localparam logic [1:0] STS_BUSY  = 2'd2;

    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;
    localparam logic [1:0] KIND_TEXT   = 2'd3;

    localparam logic [1:0] SCAN_HIT  = 2'd0;
    localparam logic [1:0] SCAN_NEXT = 2'd1;
    localparam logic [1:0] SCAN_PREV = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         entry_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic [1:0]         widget_kind;
        logic               is_active;
        logic               grayed_out;
        logic               skip_focus;
        logic [2:0]         mouse_button;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       hit_found;
        logic [5:0] hit_index;
        logic       focus_valid;
        logic [5:0] focus_index;
        logic       held_valid;
        logic [5:0] held_index;
        logic [2:0] held_button;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic               focusable;
    } t_entry;

    typedef struct packed {
        logic       start;
        logic [1:0] mode;
        logic       focus_has;
    } t_scan_cmd;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_res;

endpackage

FILE: hw/rtl/widget_hit_test_and_focus_table.sv
// Widget hit-test and focus table, top level; uses whft_pkg, whft_mem, whft_scan.
// Write, hold, release and no-op items go through the execute and done states; hit
// tests and focus searches also scan the table, focus searches in up to two passes.
// One item at a time; the table read port walks one entry per cycle.
// Reset clears count, focus and hold; table contents stay undefined until written.
`timescale 1ns / 1ps

module widget_hit_test_and_focus_table #(
    parameter int MAX_WIDGETS = whft_pkg::MAX_WIDGETS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  whft_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output whft_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_wdata
);
    import whft_pkg::*;
    `include "widget_hit_test_and_focus_table_assert.svh"

    localparam int IW = $clog2(MAX_WIDGETS);
    localparam int NW = $clog2(MAX_WIDGETS + 1);
    localparam int CW = (NW > 7) ? NW : 7;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    r_state;
    t_in_item      r_item;
    logic [6:0]    r_wcount;
    logic          r_focus_has;
    logic [IW-1:0] r_focus;
    logic          r_held_has;
    logic [5:0]    r_held;
    logic [2:0]    r_held_btn;
    logic [1:0]    r_status;
    logic          r_hit_found;
    logic [5:0]    r_hit_idx;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [NW-1:0] used;
    logic          idx_fits, idx_in_use, out_free, accept, load, is_focus;
    t_entry        wdata, rdata;
    logic          mem_we, rd_en;
    logic [IW-1:0] rd_addr, scan_idx;
    t_scan_cmd     cmd;
    t_scan_res     res;

    always_comb begin
        used = (CW'(r_wcount) > CW'(MAX_WIDGETS)) ? NW'(MAX_WIDGETS) : NW'(r_wcount);
        idx_fits   = 32'(r_item.entry_index) < 32'(MAX_WIDGETS);
        idx_in_use = 32'(r_item.entry_index) < 32'(used);
        is_focus   = (r_item.action == ACT_NEXT) || (r_item.action == ACT_PREV);
        out_free   = !r_out_valid || !i_out_stall;
        accept     = i_in_valid && !o_in_stall;
        load       = (r_state == ST_DONE) && out_free;

        wdata.left      = r_item.pos_x;
        wdata.top       = r_item.pos_y;
        wdata.width     = r_item.rect_width;
        wdata.height    = r_item.rect_height;
        wdata.focusable = r_item.is_active &&
            ((r_item.widget_kind == KIND_BUTTON && !r_item.grayed_out && !r_item.skip_focus) ||
             r_item.widget_kind == KIND_LIST || r_item.widget_kind == KIND_TEXT);
        mem_we = (r_state == ST_EXEC) && (r_item.action == ACT_WRITE) && idx_fits;

        cmd.start = (r_state == ST_EXEC) &&
            ((r_item.action == ACT_HIT) || (is_focus && used != '0));
        cmd.mode = (r_item.action == ACT_HIT)  ? SCAN_HIT :
                   (r_item.action == ACT_NEXT) ? SCAN_NEXT : SCAN_PREV;
        cmd.focus_has = r_focus_has;
    end

    whft_mem #(.MAX_WIDGETS(MAX_WIDGETS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (IW'(r_item.entry_index)),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    whft_scan #(.MAX_WIDGETS(MAX_WIDGETS)) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_count   (used),
        .i_focus   (r_focus),
        .i_pt_x    (r_item.pos_x),
        .i_pt_y    (r_item.pos_y),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rdata),
        .o_res     (res),
        .o_index   (scan_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wcount    <= '0;
            r_focus_has <= 1'b0;
            r_focus     <= '0;
            r_held_has  <= 1'b0;
            r_held      <= '0;
            r_held_btn  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wcount <= i_cfg_wdata;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= cmd.start ? ST_SCAN : ST_DONE;
                    if (r_item.action == ACT_HOLD && idx_in_use && !r_held_has) begin
                        r_held_has <= 1'b1;
                        r_held     <= r_item.entry_index;
                        r_held_btn <= r_item.mouse_button;
                    end
                    if (r_item.action == ACT_RELEASE && idx_in_use) begin
                        r_held_has <= 1'b0;
                        r_held     <= '0;
                        r_held_btn <= '0;
                    end
                end
                ST_SCAN: begin
                    if (res.done) begin
                        r_state <= ST_DONE;
                        if (r_item.action != ACT_HIT) begin
                            r_focus_has <= res.found;
                            r_focus     <= res.found ? scan_idx : '0;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item      <= i_in_item;
            r_status    <= STS_OK;
            r_hit_found <= 1'b0;
            r_hit_idx   <= '0;
        end
        if (r_state == ST_EXEC) begin
            unique case (r_item.action)
                ACT_WRITE: begin
                    if (!idx_fits) begin
                        r_status <= STS_RANGE;
                    end
                end
                ACT_HOLD: begin
                    if (!idx_in_use) begin
                        r_status <= STS_RANGE;
                    end else if (r_held_has) begin
                        r_status <= STS_BUSY;
                    end
                end
                ACT_RELEASE: begin
                    if (!idx_in_use) begin
                        r_status <= STS_RANGE;
                    end
                end
                default: begin
                    r_status <= r_status;
                end
            endcase
        end
        if (r_state == ST_SCAN && res.done && r_item.action == ACT_HIT) begin
            r_hit_found <= res.found;
            r_hit_idx   <= res.found ? 6'(scan_idx) : 6'd0;
        end
        if (load) begin
            r_out.status      <= r_status;
            r_out.hit_found   <= r_hit_found;
            r_out.hit_index   <= r_hit_idx;
            r_out.focus_valid <= r_focus_has;
            r_out.focus_index <= 6'(r_focus);
            r_out.held_valid  <= r_held_has;
            r_out.held_index  <= r_held;
            r_out.held_button <= r_held_btn;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `WHFT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "item taken while busy")
    `WHFT_ASSERT_NOW(a_focus_not_root, i_clk, i_rst_n, r_focus_has, r_focus != '0, "focus on root entry")
    `WHFT_ASSERT_NOW(a_hold_clear, i_clk, i_rst_n, !r_held_has, r_held == 6'd0 && r_held_btn == 3'd0, "stale hold state")

endmodule

FILE: hw/rtl/whft_mem.sv
// Entry table: one write port, one read port with registered read data.
// Depends on whft_pkg for the entry type.
`timescale 1ns / 1ps

module whft_mem #(
    parameter int MAX_WIDGETS = whft_pkg::MAX_WIDGETS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(MAX_WIDGETS)-1:0]   i_waddr,
    input  whft_pkg::t_entry                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(MAX_WIDGETS)-1:0]   i_raddr,
    output whft_pkg::t_entry                 o_rdata
);
    import whft_pkg::*;

    t_entry r_mem [MAX_WIDGETS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/whft_scan.sv
// Scan engine: walks the entry table one entry per cycle for hit tests
// and focus searches, in up to two passes. Depends on whft_pkg.
`timescale 1ns / 1ps

module whft_scan #(
    parameter int MAX_WIDGETS = whft_pkg::MAX_WIDGETS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  whft_pkg::t_scan_cmd                i_cmd,
    input  logic [$clog2(MAX_WIDGETS+1)-1:0]   i_count,
    input  logic [$clog2(MAX_WIDGETS)-1:0]     i_focus,
    input  logic signed [15:0]                 i_pt_x,
    input  logic signed [15:0]                 i_pt_y,
    output logic                               o_rd_en,
    output logic [$clog2(MAX_WIDGETS)-1:0]     o_rd_addr,
    input  whft_pkg::t_entry                   i_rd_data,
    output whft_pkg::t_scan_res                o_res,
    output logic [$clog2(MAX_WIDGETS)-1:0]     o_index
);
    import whft_pkg::*;
    `include "widget_hit_test_and_focus_table_assert.svh"

    localparam int IW = $clog2(MAX_WIDGETS);
    localparam int NW = $clog2(MAX_WIDGETS + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic          r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    logic          r_desc, n_desc;
    logic [NW-1:0] r_ptr, n_ptr;
    logic [NW-1:0] r_lo, n_lo;
    logic [NW-1:0] r_hi, n_hi;
    logic          r_iss, n_iss;
    logic          r_p2_pend, n_p2_pend;
    logic          r_chk_vld, n_chk_vld;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic          r_done, n_done;
    logic          r_found, n_found;
    logic [IW-1:0] r_index, n_index;

    logic          desc, p1_use, p2_has, p1_live, p2_live, pd, last, match;
    logic [NW-1:0] foc_ext, p1_lo, p1_hi, p1_ptr, p2_ptr;
    logic signed [16:0] x_end, y_end, pt_x, pt_y;
    logic          in_x, in_y;

    // pass bounds, half-open [lo, hi)
    always_comb begin
        foc_ext = NW'(i_focus);
        desc    = 1'b1;
        p1_lo   = '0;
        p1_hi   = i_count;
        p1_use  = 1'b0;
        p2_has  = 1'b0;
        unique case (i_cmd.mode)
            SCAN_HIT: begin
                p1_use = 1'b1;
            end
            SCAN_NEXT: begin
                desc   = 1'b0;
                p1_lo  = foc_ext + NW'(1);
                p1_use = i_cmd.focus_has;
                p2_has = 1'b1;
            end
            SCAN_PREV: begin
                p1_lo  = NW'(1);
                p1_hi  = (foc_ext < i_count) ? foc_ext : i_count;
                p1_use = i_cmd.focus_has;
                p2_has = 1'b1;
            end
            default: begin
                p1_use = 1'b0;
            end
        endcase
        p1_live = p1_use && (p1_lo < p1_hi);
        p1_ptr  = desc ? (p1_hi - NW'(1)) : p1_lo;
        p2_live = NW'(1) < i_count;
        pd      = (r_state == S_IDLE) ? desc : r_desc;
        p2_ptr  = pd ? (i_count - NW'(1)) : NW'(1);
        last    = r_desc ? (r_ptr == r_lo) : ((r_ptr + NW'(1)) == r_hi);
    end

    // containment test, half-open bounds
    always_comb begin
        pt_x  = 17'(i_pt_x);
        pt_y  = 17'(i_pt_y);
        x_end = 17'(i_rd_data.left) + $signed({2'b00, i_rd_data.width});
        y_end = 17'(i_rd_data.top) + $signed({2'b00, i_rd_data.height});
        in_x  = (i_pt_x >= i_rd_data.left) && (pt_x < x_end);
        in_y  = (i_pt_y >= i_rd_data.top) && (pt_y < y_end);
        match = r_chk_vld && ((r_mode == SCAN_HIT) ? (in_x && in_y) : i_rd_data.focusable);
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_desc    = r_desc;
        n_ptr     = r_ptr;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_iss     = r_iss;
        n_p2_pend = r_p2_pend;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        n_done    = 1'b0;
        n_found   = r_found;
        n_index   = r_index;
        if (r_state == S_IDLE) begin
            if (i_cmd.start) begin
                n_state   = S_RUN;
                n_mode    = i_cmd.mode;
                n_desc    = desc;
                n_chk_vld = 1'b0;
                if (p1_live) begin
                    n_ptr     = p1_ptr;
                    n_lo      = p1_lo;
                    n_hi      = p1_hi;
                    n_iss     = 1'b1;
                    n_p2_pend = p2_has;
                end else if (p2_has && p2_live) begin
                    n_ptr     = p2_ptr;
                    n_lo      = NW'(1);
                    n_hi      = i_count;
                    n_iss     = 1'b1;
                    n_p2_pend = 1'b0;
                end else begin
                    n_iss     = 1'b0;
                    n_p2_pend = 1'b0;
                end
            end
        end else begin
            if (match) begin
                n_state   = S_IDLE;
                n_iss     = 1'b0;
                n_chk_vld = 1'b0;
                n_p2_pend = 1'b0;
                n_done    = 1'b1;
                n_found   = 1'b1;
                n_index   = r_chk_idx;
            end else if (!r_iss && !r_chk_vld) begin
                if (r_p2_pend && p2_live) begin
                    n_ptr     = p2_ptr;
                    n_lo      = NW'(1);
                    n_hi      = i_count;
                    n_iss     = 1'b1;
                    n_p2_pend = 1'b0;
                end else begin
                    n_state   = S_IDLE;
                    n_p2_pend = 1'b0;
                    n_done    = 1'b1;
                    n_found   = 1'b0;
                    n_index   = '0;
                end
            end else begin
                n_chk_vld = r_iss;
                n_chk_idx = r_ptr[IW-1:0];
                if (r_iss) begin
                    if (last) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ptr = r_desc ? (r_ptr - NW'(1)) : (r_ptr + NW'(1));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iss     <= 1'b0;
            r_p2_pend <= 1'b0;
            r_chk_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_iss     <= n_iss;
            r_p2_pend <= n_p2_pend;
            r_chk_vld <= n_chk_vld;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_desc    <= n_desc;
        r_ptr     <= n_ptr;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_chk_idx <= n_chk_idx;
        r_found   <= n_found;
        r_index   <= n_index;
    end

    assign o_rd_en     = (r_state == S_RUN) && r_iss;
    assign o_rd_addr   = r_ptr[IW-1:0];
    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_index     = r_index;

    `WHFT_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "scan done held")
    `WHFT_ASSERT_NOW(a_found_range, i_clk, i_rst_n, r_done && r_found, NW'(r_index) < i_count, "scan index past count")
    `WHFT_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !r_iss && !r_chk_vld, "scan active while idle")

endmodule

FILE: bench/widget_hit_test_and_focus_table_test.sv
// Self-checking bench for widget_hit_test_and_focus_table: table fill, directed
// edge cases, then random phases with varying widget counts and random idling.
// Depends on whft_pkg and the RTL top level only.
`timescale 1ns / 1ps

module widget_hit_test_and_focus_table_test;
    import whft_pkg::*;

    localparam int N_ENTRIES = MAX_WIDGETS_DEF;
    localparam logic [2:0] ACT_NOP_A = 3'd6;
    localparam logic [2:0] ACT_NOP_B = 3'd7;
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam int ITEM_TARGET = 1350;
    localparam int DRAIN_CYCLES = 2 * N_ENTRIES + 16;

    typedef struct {
        int        cfg;
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_directed_step;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    logic      cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;

    // shadow state of the block
    t_entry     wtab [N_ENTRIES];
    logic [6:0] wcount = '0;
    bit         foc_has = 1'b0;
    logic [5:0] foc_idx = '0;
    bit         hold_has = 1'b0;
    logic [5:0] hold_idx = '0;
    logic [2:0] hold_btn = '0;

    t_out_item      pending_responses [$];
    t_directed_step script [$];
    int failures = 0;
    int items_sent = 0;
    int hits = 0;
    int focus_moves = 0;
    int grants = 0;
    int settings = 0;
    int cyc = 0;
    bit quiet = 1'b0;
    int stall_left = 0;

    widget_hit_test_and_focus_table #(
        .MAX_WIDGETS(N_ENTRIES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        quiet <= (cyc % 3000) >= 2400;
    end

    function automatic int live_count();
        return (wcount > 7'(N_ENTRIES)) ? N_ENTRIES : int'(wcount);
    endfunction

    function automatic void move_focus(bit forward);
        int n;
        int i;
        int start;
        bit found;
        n = live_count();
        found = 1'b0;
        if (forward) begin
            if (foc_has) begin
                for (i = int'(foc_idx) + 1; i < n && !found; i++) begin
                    if (wtab[i].focusable) begin
                        foc_idx = 6'(i);
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                foc_has = 1'b0;
                foc_idx = '0;
                for (i = 1; i < n && !found; i++) begin
                    if (wtab[i].focusable) begin
                        foc_has = 1'b1;
                        foc_idx = 6'(i);
                        found = 1'b1;
                    end
                end
            end
        end else begin
            if (foc_has) begin
                start = (int'(foc_idx) < n) ? int'(foc_idx) : n;
                for (i = start; i > 1 && !found; i--) begin
                    if (wtab[i - 1].focusable) begin
                        foc_idx = 6'(i - 1);
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                foc_has = 1'b0;
                foc_idx = '0;
                for (i = n; i > 1 && !found; i--) begin
                    if (wtab[i - 1].focusable) begin
                        foc_has = 1'b1;
                        foc_idx = 6'(i - 1);
                        found = 1'b1;
                    end
                end
            end
        end
    endfunction

    function automatic t_out_item table_response(t_in_item it);
        t_out_item r;
        int n;
        int i;
        int px;
        int py;
        int l;
        int t;
        r = '0;
        n = live_count();
        px = $signed(it.pos_x);
        py = $signed(it.pos_y);
        case (it.action)
            ACT_WRITE: begin
                wtab[it.entry_index].left = it.pos_x;
                wtab[it.entry_index].top = it.pos_y;
                wtab[it.entry_index].width = it.rect_width;
                wtab[it.entry_index].height = it.rect_height;
                wtab[it.entry_index].focusable = it.is_active &&
                    ((it.widget_kind == KIND_BUTTON && !it.grayed_out && !it.skip_focus) ||
                     it.widget_kind == KIND_LIST || it.widget_kind == KIND_TEXT);
            end
            ACT_HIT: begin
                for (i = n - 1; i >= 0 && !r.hit_found; i--) begin
                    l = $signed(wtab[i].left);
                    t = $signed(wtab[i].top);
                    if (px >= l && px < l + int'(wtab[i].width) &&
                        py >= t && py < t + int'(wtab[i].height)) begin
                        r.hit_found = 1'b1;
                        r.hit_index = 6'(i);
                    end
                end
            end
            ACT_NEXT: begin
                if (n != 0) move_focus(1'b1);
            end
            ACT_PREV: begin
                if (n != 0) move_focus(1'b0);
            end
            ACT_HOLD: begin
                if (int'(it.entry_index) >= n) begin
                    r.status = STS_RANGE;
                end else if (hold_has) begin
                    r.status = STS_BUSY;
                end else begin
                    hold_has = 1'b1;
                    hold_idx = it.entry_index;
                    hold_btn = it.mouse_button;
                end
            end
            ACT_RELEASE: begin
                if (int'(it.entry_index) >= n) begin
                    r.status = STS_RANGE;
                end else begin
                    hold_has = 1'b0;
                    hold_idx = '0;
                    hold_btn = '0;
                end
            end
            default: begin
            end
        endcase
        r.focus_valid = foc_has;
        r.focus_index = foc_has ? foc_idx : 6'd0;
        r.held_valid = hold_has;
        r.held_index = hold_has ? hold_idx : 6'd0;
        r.held_button = hold_has ? hold_btn : 3'd0;
        return r;
    endfunction

    function automatic t_in_item req(logic [2:0] act, int idx, int x, int y, int w, int h,
                                     logic [1:0] kind, bit on, bit gray, bit skip, int btn);
        t_in_item it;
        it.action = act;
        it.entry_index = 6'(idx);
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.rect_width = 15'(w);
        it.rect_height = 15'(h);
        it.widget_kind = kind;
        it.is_active = on;
        it.grayed_out = gray;
        it.skip_focus = skip;
        it.mouse_button = 3'(btn);
        return it;
    endfunction

    function automatic t_out_item resp(logic [1:0] st, bit hf, int hi, bit fv, int fi,
                                       bit hv, int hd, int hb);
        t_out_item r;
        r.status = st;
        r.hit_found = hf;
        r.hit_index = 6'(hi);
        r.focus_valid = fv;
        r.focus_index = 6'(fi);
        r.held_valid = hv;
        r.held_index = 6'(hd);
        r.held_button = 3'(hb);
        return r;
    endfunction

    function automatic void add_step(int cfg, t_in_item it, bit typed, t_out_item res);
        t_directed_step s;
        s.cfg = cfg;
        s.item = it;
        s.typed = typed;
        s.res = res;
        script.push_back(s);
    endfunction

    function automatic string show(t_out_item r);
        return $sformatf("st=%0d hit=%0d/%0d focus=%0d/%0d held=%0d/%0d btn=%0d",
                         r.status, r.hit_found, r.hit_index, r.focus_valid, r.focus_index,
                         r.held_valid, r.held_index, r.held_button);
    endfunction

    function automatic int gap_cycles();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item raw_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return t_in_item'(raw[$bits(t_in_item)-1:0]);
    endfunction

    // mostly small rectangles around the origin so that points land in them
    function automatic t_in_item shaped_write(t_in_item it);
        it.action = ACT_WRITE;
        if ($urandom_range(0, 4) != 0) begin
            it.pos_x = 16'(int'($urandom_range(0, 127)) - 64);
            it.pos_y = 16'(int'($urandom_range(0, 127)) - 64);
            it.rect_width = 15'($urandom_range(0, 40));
            it.rect_height = 15'($urandom_range(0, 40));
        end
        it.is_active = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    function automatic int point_near(int lo, int span);
        case ($urandom_range(0, 4))
            0: return lo - 1;
            1: return lo;
            2: return lo + span - 1;
            3: return lo + span;
            default: return lo + int'($urandom_range(0, (span > 0) ? span - 1 : 0));
        endcase
    endfunction

    function automatic t_in_item random_request();
        t_in_item it;
        int n;
        int r;
        int j;
        it = raw_item();
        n = live_count();
        r = $urandom_range(0, 99);
        if (r < 25) begin
            it = shaped_write(it);
        end else if (r < 55) begin
            it.action = ACT_HIT;
            r = $urandom_range(0, 99);
            if (n > 0 && r < 60) begin
                j = $urandom_range(0, n - 1);
                it.pos_x = 16'(point_near($signed(wtab[j].left), int'(wtab[j].width)));
                it.pos_y = 16'(point_near($signed(wtab[j].top), int'(wtab[j].height)));
            end else if (r < 80) begin
                it.pos_x = 16'(int'($urandom_range(0, 140)) - 70);
                it.pos_y = 16'(int'($urandom_range(0, 140)) - 70);
            end
        end else if (r < 67) begin
            it.action = ACT_NEXT;
        end else if (r < 79) begin
            it.action = ACT_PREV;
        end else if (r < 96) begin
            it.action = (r < 88) ? ACT_HOLD : ACT_RELEASE;
            if (n > 0 && $urandom_range(0, 3) != 0)
                it.entry_index = 6'($urandom_range(0, n - 1));
        end else begin
            it.action = $urandom_range(0, 1) ? ACT_NOP_A : ACT_NOP_B;
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        int gap;
        t_out_item pred;
        gap = gap_cycles();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        pred = table_response(it);
        pending_responses.push_back(typed ? typed_res : pred);
        if (it.action <= ACT_RELEASE) items_sent++;
        if (pred.hit_found) hits++;
        if ((it.action == ACT_NEXT || it.action == ACT_PREV) && pred.focus_valid)
            focus_moves++;
        if (it.action == ACT_HOLD && pred.status == STS_OK) grants++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_widget_count(input int v);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= 7'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        wcount = 7'(v);
        settings++;
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 99) < 30) stall_left = gap_cycles();
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        string bad;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_responses.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result %s", $time, show(out_item));
            end else begin
                want = pending_responses.pop_front();
                bad = "";
                if (out_item.status !== want.status) bad = {bad, " status"};
                if (out_item.hit_found !== want.hit_found) bad = {bad, " hit_found"};
                if (out_item.hit_index !== want.hit_index) bad = {bad, " hit_index"};
                if (out_item.focus_valid !== want.focus_valid) bad = {bad, " focus_valid"};
                if (out_item.focus_index !== want.focus_index) bad = {bad, " focus_index"};
                if (out_item.held_valid !== want.held_valid) bad = {bad, " held_valid"};
                if (out_item.held_index !== want.held_index) bad = {bad, " held_index"};
                if (out_item.held_button !== want.held_button) bad = {bad, " held_button"};
                if (bad != "") begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: mismatch on%s: expected %s, got %s",
                                 $time, bad, show(want), show(out_item));
                end
            end
        end
    end

    initial begin
        t_in_item it;
        t_out_item idle_resp;
        int i;
        int r;
        int v;
        int phase_len;

        for (i = 0; i < N_ENTRIES; i++) wtab[i] = '0;
        idle_resp = resp(STS_OK, 0, 0, 0, 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill every entry so no scan ever reads an unwritten one
        for (i = 0; i < N_ENTRIES; i++) begin
            it = shaped_write(raw_item());
            it.entry_index = 6'(i);
            send_item(it, 1'b0, idle_resp);
        end

        add_step(0, req(ACT_HIT, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1, idle_resp);
        add_step(-1, req(ACT_NEXT, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1, idle_resp);
        add_step(-1, req(ACT_PREV, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1, idle_resp);
        add_step(-1, req(ACT_HOLD, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 5), 1,
                 resp(STS_RANGE, 0, 0, 0, 0, 0, 0, 0));
        add_step(-1, req(ACT_RELEASE, 63, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 resp(STS_RANGE, 0, 0, 0, 0, 0, 0, 0));
        add_step(-1, req(ACT_NOP_A, 63, -1, -1, 32767, 32767, KIND_TEXT, 1, 1, 1, 7), 1,
                 idle_resp);
        add_step(-1, req(ACT_WRITE, 0, -32768, -32768, 32767, 32767, KIND_OTHER, 1, 0, 0, 0),
                 1, idle_resp);
        add_step(-1, req(ACT_WRITE, 63, 32767, 32767, 32767, 32767, KIND_BUTTON, 1, 0, 0, 0),
                 1, idle_resp);
        add_step(-1, req(ACT_WRITE, 1, 0, 0, 0, 10, KIND_BUTTON, 1, 1, 0, 0), 1, idle_resp);
        add_step(-1, req(ACT_WRITE, 2, 0, 0, 10, 10, KIND_BUTTON, 1, 0, 1, 0), 1, idle_resp);
        add_step(-1, req(ACT_WRITE, 3, -5, -5, 10, 10, KIND_LIST, 0, 0, 0, 0), 1, idle_resp);
        add_step(-1, req(ACT_WRITE, 4, 0, 0, 1, 1, KIND_TEXT, 1, 0, 0, 0), 1, idle_resp);
        add_step(64, req(ACT_HIT, 0, 32767, 32767, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 resp(STS_OK, 1, 63, 0, 0, 0, 0, 0));
        add_step(5, req(ACT_HIT, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 resp(STS_OK, 1, 4, 0, 0, 0, 0, 0));
        add_step(-1, req(ACT_HIT, 0, 1, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 resp(STS_OK, 1, 3, 0, 0, 0, 0, 0));
        add_step(-1, req(ACT_HIT, 0, 32767, 32767, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 idle_resp);
        add_step(-1, req(ACT_NEXT, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 resp(STS_OK, 0, 0, 1, 4, 0, 0, 0));
        add_step(-1, req(ACT_PREV, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 resp(STS_OK, 0, 0, 1, 4, 0, 0, 0));
        add_step(-1, req(ACT_HOLD, 4, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 7), 1,
                 resp(STS_OK, 0, 0, 1, 4, 1, 4, 7));
        add_step(-1, req(ACT_HOLD, 2, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 1), 1,
                 resp(STS_BUSY, 0, 0, 1, 4, 1, 4, 7));
        add_step(-1, req(ACT_HOLD, 5, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 3), 1,
                 resp(STS_RANGE, 0, 0, 1, 4, 1, 4, 7));
        add_step(3, req(ACT_NEXT, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 resp(STS_OK, 0, 0, 0, 0, 1, 4, 7));
        add_step(-1, req(ACT_RELEASE, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1, idle_resp);
        add_step(127, req(ACT_PREV, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 0, idle_resp);
        add_step(-1, req(ACT_HOLD, 63, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 0, idle_resp);
        add_step(1, req(ACT_NEXT, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1,
                 resp(STS_OK, 0, 0, 0, 0, 1, 63, 0));

        foreach (script[k]) begin
            if (script[k].cfg >= 0) set_widget_count(script[k].cfg);
            send_item(script[k].item, script[k].typed, script[k].res);
        end

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 8) v = 0;
            else if (r < 16) v = 1;
            else if (r < 22) v = 2;
            else if (r < 40) v = N_ENTRIES;
            else if (r < 45) v = 127;
            else if (r < 52) v = $urandom_range(N_ENTRIES + 1, 126);
            else v = $urandom_range(3, N_ENTRIES - 1);
            set_widget_count(v);
            phase_len = $urandom_range(15, 70);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) == 0) settle();
                send_item(random_request(), 1'b0, idle_resp);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d items over %0d widget counts: %0d hits, %0d focus moves, %0d holds",
                 items_sent, settings, hits, focus_moves, grants);
        $display("%0d result errors", failures);
        if (failures == 0 && pending_responses.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
